[rtl/core/kbi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbi_pkg
// Shared types, constants and the base letter decoder of the k-mer bucket
// indexer.
// ----------------------------------------------------------------------------
package kbi_pkg;

  localparam int unsigned KEY_W          = 16;
  localparam int unsigned CNT_W          = 32;
  localparam int unsigned FIELD_W        = 32;
  localparam int unsigned HEAD_DEPTH     = 65536;
  localparam int unsigned KMER_LEN_DEF   = 8;
  localparam int unsigned ENTRY_BITS_DEF = 32;

  localparam logic [31:0] SEQ_OFFSET_RST = 32'd1;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [7:0] LETTER_A = 8'h41;
  localparam logic [7:0] LETTER_C = 8'h43;
  localparam logic [7:0] LETTER_G = 8'h47;
  localparam logic [7:0] LETTER_T = 8'h54;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  typedef struct packed {
    logic       known;
    logic [1:0] code;
  } base_t;

  // Work handed from the key roller to the head table stage
  typedef struct packed {
    logic             ins;
    logic             rd;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] ix;
  } issue_t;

  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] key;
  } wr_t;

  function automatic base_t base_decode(input logic [7:0] letter);
    base_t res;
    res.known = 1'b1;
    res.code  = CODE_A;
    case (letter)
      LETTER_A: res.code = CODE_A;
      LETTER_C: res.code = CODE_C;
      LETTER_G: res.code = CODE_G;
      LETTER_T: res.code = CODE_T;
      default: begin
        res.known = 1'b0;
        res.code  = CODE_A;
      end
    endcase
    return res;
  endfunction

endpackage

[rtl/core/kbi_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbi_ram
// Generic single-clock RAM, one write port and one read port with a
// registered read. A read at the address being written returns old data.
// ----------------------------------------------------------------------------
module kbi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/kbi_roller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbi_roller
// Rolling k-mer key, N mask, base counter and free entry counter. Decides
// per item whether an entry is inserted and which bucket is addressed.
// ----------------------------------------------------------------------------
module kbi_roller #(
  parameter int unsigned KMER_LEN   = kbi_pkg::KMER_LEN_DEF,
  parameter int unsigned ENTRY_BITS = kbi_pkg::ENTRY_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       action_i,
  input  logic [7:0]                 base_letter_i,
  input  logic                       seq_start_i,
  input  logic [kbi_pkg::KEY_W-1:0]  query_key_i,
  input  logic [31:0]                seq_offset_i,
  output kbi_pkg::issue_t            issue_o,
  output logic [ENTRY_BITS-1:0]      entry_o
);

  localparam int unsigned KEY_BITS = (2 * KMER_LEN > kbi_pkg::KEY_W) ?
                                     kbi_pkg::KEY_W : 2 * KMER_LEN;
  localparam logic [kbi_pkg::KEY_W-1:0] KEY_MASK =
    kbi_pkg::KEY_W'((33'd1 << KEY_BITS) - 33'd1);
  localparam logic [kbi_pkg::CNT_W-1:0] K_LEN  = kbi_pkg::CNT_W'(KMER_LEN);
  localparam logic [kbi_pkg::CNT_W-1:0] K_LAST = kbi_pkg::CNT_W'(KMER_LEN - 1);

  logic [kbi_pkg::KEY_W-1:0] key_q, key_d, key0, key1;
  logic [kbi_pkg::CNT_W-1:0] mask_q, mask_d, mask0, mask1;
  logic [kbi_pkg::CNT_W-1:0] cnt_q, cnt_d, ix;
  logic [ENTRY_BITS-1:0]     free_q, free_d, free0;
  kbi_pkg::base_t            base;
  logic                      emit;
  logic                      push;

  always_comb begin
    push  = (action_i == kbi_pkg::ACT_PUSH);
    base  = kbi_pkg::base_decode(base_letter_i);
    key0  = seq_start_i ? '0 : key_q;
    mask0 = seq_start_i ? '0 : mask_q;
    ix    = seq_start_i ? '0 : cnt_q;
    free0 = seq_start_i ? seq_offset_i[ENTRY_BITS-1:0] : free_q;

    mask1 = base.known ? mask0 : ix + K_LEN;
    key1  = {key0[kbi_pkg::KEY_W-3:0], base.code} & KEY_MASK;
    emit  = (ix >= K_LAST) && (ix >= mask1);

    issue_o.ins = push && emit;
    issue_o.rd  = !push;
    issue_o.key = push ? key1 : query_key_i;
    issue_o.ix  = ix;
    entry_o     = free0;

    key_d  = key_q;
    mask_d = mask_q;
    cnt_d  = cnt_q;
    free_d = free_q;
    if (accept_i && push) begin
      key_d  = key1;
      mask_d = mask1;
      cnt_d  = ix + kbi_pkg::CNT_W'(1);
      free_d = emit ? free0 + ENTRY_BITS'(1) : free0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      mask_q <= '0;
      cnt_q  <= '0;
      free_q <= kbi_pkg::SEQ_OFFSET_RST[ENTRY_BITS-1:0];
    end else begin
      key_q  <= key_d;
      mask_q <= mask_d;
      cnt_q  <= cnt_d;
      free_q <= free_d;
    end
  end

endmodule

[rtl/core/kbi_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbi_update
// Head table stage: takes the registered read, forwards a write to the same
// bucket made at the read edge, writes the new head back and fills the
// output register.
// ----------------------------------------------------------------------------
module kbi_update #(
  parameter int unsigned KMER_LEN   = kbi_pkg::KMER_LEN_DEF,
  parameter int unsigned ENTRY_BITS = kbi_pkg::ENTRY_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  kbi_pkg::issue_t       issue_i,
  input  logic [ENTRY_BITS-1:0] entry_i,
  input  logic [31:0]           seq_offset_i,
  input  logic [ENTRY_BITS-1:0] rd_data_i,
  output logic                  take_o,
  output kbi_pkg::wr_t          wr_o,
  output logic [ENTRY_BITS-1:0] wr_data_o,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output logic                  m_entry_valid_o,
  output logic [31:0]           m_entry_index_o,
  output logic [31:0]           m_position_o,
  output logic [31:0]           m_next_entry_o,
  output logic [15:0]           m_bucket_key_o,
  output logic [31:0]           m_head_entry_o
);

  localparam logic [31:0] K_LAST = 32'(KMER_LEN - 1);

  logic                      s1_valid_q, s1_valid_d;
  logic                      s1_ins_q;
  logic [kbi_pkg::KEY_W-1:0] s1_key_q;
  logic [kbi_pkg::CNT_W-1:0] s1_ix_q;
  logic [ENTRY_BITS-1:0]     s1_entry_q;
  logic                      s1_fwd_q;
  logic [ENTRY_BITS-1:0]     s1_fwd_data_q;
  logic                      s1_move;
  logic                      load;
  logic [ENTRY_BITS-1:0]     head;

  logic        m_valid_q, m_valid_d;
  logic        m_ev_q;
  logic [31:0] m_idx_q, m_pos_q, m_next_q, m_head_q;
  logic [15:0] m_key_q;

  always_comb begin
    s1_move   = s1_valid_q && (!m_valid_q || m_ready_i);
    take_o    = !s1_valid_q || s1_move;
    load      = accept_i && (issue_i.ins || issue_i.rd);
    head      = s1_fwd_q ? s1_fwd_data_q : rd_data_i;
    wr_o.en   = s1_move && s1_ins_q;
    wr_o.key  = s1_key_q;
    wr_data_o = s1_entry_q;

    s1_valid_d = s1_valid_q;
    if (load) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end

    m_valid_d = m_valid_q;
    if (s1_move) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // The read issued at this edge misses a write to the same bucket at this edge
  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_ins_q      <= issue_i.ins;
      s1_key_q      <= issue_i.key;
      s1_ix_q       <= issue_i.ix;
      s1_entry_q    <= entry_i;
      s1_fwd_q      <= wr_o.en && (wr_o.key == issue_i.key);
      s1_fwd_data_q <= s1_entry_q;
    end
    if (s1_move) begin
      m_ev_q <= s1_ins_q;
      if (s1_ins_q) begin
        m_idx_q  <= 32'(s1_entry_q);
        m_pos_q  <= s1_ix_q - K_LAST + seq_offset_i;
        m_next_q <= 32'(head);
        m_key_q  <= s1_key_q;
        m_head_q <= '0;
      end else begin
        m_idx_q  <= '0;
        m_pos_q  <= '0;
        m_next_q <= '0;
        m_key_q  <= '0;
        m_head_q <= 32'(head);
      end
    end
  end

  assign m_valid_o       = m_valid_q;
  assign m_entry_valid_o = m_ev_q;
  assign m_entry_index_o = m_idx_q;
  assign m_position_o    = m_pos_q;
  assign m_next_entry_o  = m_next_q;
  assign m_bucket_key_o  = m_key_q;
  assign m_head_entry_o  = m_head_q;

endmodule

[rtl/core/kmer_bucket_indexer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_bucket_indexer
// Rolling 2-bit k-mer hash with a bucket head table.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one item per base push or head read. tuser selects read
//   versus push and flags the first base of a sequence; tdata carries the
//   letter and the query key. Master stream: one item per insertion or read;
//   tuser marks an insertion, tdata carries index, position, link, key, head.
//   A push that completes no unmasked k-mer window yields no item.
//   Config channel: writes the sequence offset (always ready); write it only
//   while no items are in flight.
// Throughput: one item per cycle while the master side keeps up. The head
//   table is read at the accept edge and written back as the item leaves the
//   table stage; a write to the same bucket at the read edge is forwarded,
//   so equal keys back to back keep full rate.
// Reset: the head table is cleared by a sweep over all 65536 entries, one
//   entry per cycle; s_axis_tready stays low until the sweep ends.
// Stall: a result waits in the output register; one more item may sit in the
//   table stage, after which s_axis_tready drops until the master side moves.
// ----------------------------------------------------------------------------
module kmer_bucket_indexer #(
  parameter int unsigned KMER_LEN   = kbi_pkg::KMER_LEN_DEF,
  parameter int unsigned ENTRY_BITS = kbi_pkg::ENTRY_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // base_letter, query_key
  input  logic [1:0]   s_axis_tuser,   // action, seq_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,   // entry_index, position, next_entry,
                                       // bucket_key, head_entry
  output logic [0:0]   m_axis_tuser,   // entry_valid
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_wdata_i
);

  localparam int unsigned ADDR_W = $clog2(kbi_pkg::HEAD_DEPTH);

  logic [31:0]           offset_q;
  logic                  clr_busy_q;
  logic [ADDR_W-1:0]     clr_addr_q;
  logic                  accept;
  logic                  take;
  kbi_pkg::issue_t       issue;
  logic [ENTRY_BITS-1:0] entry;
  kbi_pkg::wr_t          upd_wr;
  logic [ENTRY_BITS-1:0] upd_wr_data;
  logic [ENTRY_BITS-1:0] rd_data;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ENTRY_BITS-1:0] ram_wdata;
  logic                  ev;
  logic [31:0]           o_idx, o_pos, o_next, o_head;
  logic [15:0]           o_key;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !clr_busy_q && take;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= kbi_pkg::SEQ_OFFSET_RST;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        offset_q <= cfg_wdata_i;
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
        if (&clr_addr_q) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  kbi_roller #(
    .KMER_LEN   (KMER_LEN),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_roller (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .action_i      (s_axis_tuser[0]),
    .base_letter_i (s_axis_tdata[7:0]),
    .seq_start_i   (s_axis_tuser[1]),
    .query_key_i   (s_axis_tdata[23:8]),
    .seq_offset_i  (offset_q),
    .issue_o       (issue),
    .entry_o       (entry)
  );

  // Clear sweep owns the write port until done
  assign ram_we    = clr_busy_q || upd_wr.en;
  assign ram_waddr = clr_busy_q ? clr_addr_q : upd_wr.key;
  assign ram_wdata = clr_busy_q ? '0 : upd_wr_data;

  kbi_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (kbi_pkg::HEAD_DEPTH)
  ) u_heads (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (issue.key),
    .rdata_o (rd_data)
  );

  kbi_update #(
    .KMER_LEN   (KMER_LEN),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_update (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .issue_i         (issue),
    .entry_i         (entry),
    .seq_offset_i    (offset_q),
    .rd_data_i       (rd_data),
    .take_o          (take),
    .wr_o            (upd_wr),
    .wr_data_o       (upd_wr_data),
    .m_valid_o       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .m_entry_valid_o (ev),
    .m_entry_index_o (o_idx),
    .m_position_o    (o_pos),
    .m_next_entry_o  (o_next),
    .m_bucket_key_o  (o_key),
    .m_head_entry_o  (o_head)
  );

  assign m_axis_tuser = ev;
  assign m_axis_tdata = {o_head, o_key, o_next, o_pos, o_idx};

  a_no_accept_in_clear : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready
  ) else $error("item accepted during head table clear");

  a_no_write_in_clear : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !upd_wr.en
  ) else $error("table write during clear sweep");

  a_insert_no_head : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[143:112] == 32'd0)
  ) else $error("insertion result carries a head entry");

  a_read_no_entry : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[31:0] == 32'd0)
  ) else $error("read result carries an entry index");

endmodule

[tb/sv/kmer_bucket_indexer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_bucket_indexer_checker
// Watches the base stream, the result stream and the offset writes of the
// k-mer bucket indexer. It rolls its own key, mask and bucket head table from
// every accepted item and compares each accepted result, field by field, with
// the oldest predicted result.
// ----------------------------------------------------------------------------
module kmer_bucket_indexer_checker
  import kbi_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [23:0]  s_tdata_i,   // base_letter, query_key
  input  logic [1:0]   s_tuser_i,   // action, seq_start
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [143:0] m_tdata_i,   // entry_index, position, next_entry,
                                    // bucket_key, head_entry
  input  logic [0:0]   m_tuser_i,   // entry_valid
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [31:0]  cfg_wdata_i,
  output int           pending_o,
  output int           errors_o
);

  localparam int unsigned KMER_LEN = KMER_LEN_DEF;

  typedef struct packed {
    logic             ins;
    logic [31:0]      idx;
    logic [31:0]      pos;
    logic [31:0]      link;
    logic [KEY_W-1:0] key;
    logic [31:0]      head;
  } index_result_t;

  index_result_t    index_results_q[$];
  logic [31:0]      head_table [HEAD_DEPTH];
  logic [31:0]      seq_offset;
  logic [KEY_W-1:0] roll_key;
  logic [31:0]      mask_end;
  logic [31:0]      base_cnt;
  logic [31:0]      next_free;
  int               mismatches;

  task automatic index_base(input logic act, input logic [7:0] letter,
                            input logic start, input logic [KEY_W-1:0] qkey);
    index_result_t res;
    logic [31:0]   ix;
    logic [1:0]    code;
    logic          known;
    res = '0;
    if (act == ACT_READ) begin
      res.head = head_table[qkey];
      index_results_q.push_back(res);
    end else begin
      if (start) begin
        roll_key  = '0;
        mask_end  = '0;
        base_cnt  = '0;
        next_free = seq_offset;
      end
      ix    = base_cnt;
      known = 1'b1;
      case (letter)
        LETTER_A: code = CODE_A;
        LETTER_C: code = CODE_C;
        LETTER_G: code = CODE_G;
        LETTER_T: code = CODE_T;
        default: begin
          known = 1'b0;
          code  = CODE_A;
        end
      endcase
      // an unknown letter hides every window that covers it
      if (!known) mask_end = ix + KMER_LEN;
      roll_key = {roll_key[KEY_W-3:0], code};
      base_cnt = ix + 1;
      if (ix >= KMER_LEN - 1 && ix >= mask_end) begin
        res.ins  = 1'b1;
        res.idx  = next_free;
        res.pos  = ix - (KMER_LEN - 1) + seq_offset;
        res.link = head_table[roll_key];
        res.key  = roll_key;
        head_table[roll_key] = next_free;
        next_free = next_free + 1;
        index_results_q.push_back(res);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    index_result_t want;
    if (index_results_q.size() == 0) begin
      $display("%0t ns: result with none expected, expected none, actual %h / %h",
               $time, m_tuser_i, m_tdata_i);
      mismatches++;
    end else begin
      want = index_results_q.pop_front();
      check_field("entry_valid", 32'(want.ins), 32'(m_tuser_i[0]));
      check_field("entry_index", want.idx,  m_tdata_i[31:0]);
      check_field("position",    want.pos,  m_tdata_i[63:32]);
      check_field("next_entry",  want.link, m_tdata_i[95:64]);
      check_field("bucket_key",  32'(want.key), 32'(m_tdata_i[111:96]));
      check_field("head_entry",  want.head, m_tdata_i[143:112]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_results_q.delete();
      for (int i = 0; i < HEAD_DEPTH; i++) head_table[i] = '0;
      seq_offset = SEQ_OFFSET_RST;
      roll_key   = '0;
      mask_end   = '0;
      base_cnt   = '0;
      next_free  = SEQ_OFFSET_RST;
      mismatches = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) seq_offset = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) begin
        index_base(s_tuser_i[0], s_tdata_i[7:0], s_tuser_i[1], s_tdata_i[23:8]);
      end
      if (m_tvalid_i && m_tready_i) check_result();
      pending_o <= index_results_q.size();
      errors_o  <= mismatches;
    end
  end

endmodule

[tb/sv/kmer_bucket_indexer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_bucket_indexer_tb
// Drives base pushes and head reads into the k-mer bucket indexer: a directed
// run over letter and key extremes, masking and repeated keys, then random
// sequences under several sequence offsets and stall patterns. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module kmer_bucket_indexer_tb;
  import kbi_pkg::*;

  localparam int STYLE_ANY  = 0;
  localparam int STYLE_TWO  = 1;
  localparam int STYLE_RUNS = 2;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata;   // base_letter, query_key
  logic [1:0]   s_axis_tuser;   // action, seq_start
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;   // entry_index, position, next_entry,
                                // bucket_key, head_entry
  logic [0:0]   m_axis_tuser;   // entry_valid
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [31:0]  cfg_wdata_i;
  int           pending;
  int           errors;
  int           s_idle_pct;
  int           r_idle_pct;
  int           sent;

  kmer_bucket_indexer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  kmer_bucket_indexer_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= r_idle_pct);
    end
  end

  // covers the sweep of all 65536 table entries plus every item at its slowest
  initial begin
    #2_000_000;
    $display("** kmer_bucket_indexer: FAILED **");
    $finish;
  end

  function automatic logic [7:0] acgt_letter(input int unsigned pick);
    case (pick)
      0:       return LETTER_A;
      1:       return LETTER_C;
      2:       return LETTER_G;
      default: return LETTER_T;
    endcase
  endfunction

  // bias queries toward buckets that two-letter and homopolymer runs fill
  function automatic logic [15:0] pick_query();
    logic [15:0] k;
    k = 16'($urandom_range(65535));
    if ($urandom_range(1) != 0) k = k & 16'h5555;
    else if ($urandom_range(3) == 0) k = {8{k[1:0]}};
    return k;
  endfunction

  task automatic send_item(input logic act, input logic [7:0] letter,
                           input logic start, input logic [15:0] qkey);
    while (s_idle_pct != 0 && $urandom_range(99) < s_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {qkey, letter};
    s_axis_tuser  <= {start, act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_sequence(input int len, input int style, input int n_pct);
    logic [7:0] letter;
    logic [7:0] prev;
    prev = LETTER_A;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) begin
        send_item(ACT_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), pick_query());
      end
      if (n_pct != 0 && $urandom_range(99) < n_pct) begin
        letter = 8'($urandom_range(255));
      end else begin
        case (style)
          STYLE_TWO:  letter = ($urandom_range(1) != 0) ? LETTER_C : LETTER_A;
          STYLE_RUNS: letter = ($urandom_range(4) != 0) ? prev
                                                        : acgt_letter($urandom_range(3));
          default:    letter = acgt_letter($urandom_range(3));
        endcase
      end
      send_item(ACT_PUSH, letter, (i == 0), 16'($urandom_range(65535)));
      prev = letter;
    end
  endtask

  task automatic random_items(input int budget);
    int stop_at;
    stop_at = sent + budget;
    while (sent < stop_at) begin
      case ($urandom_range(9))
        0: send_item(ACT_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     16'($urandom_range(65535)));
        // stray push: continues or restarts whatever run is open
        1: send_item(ACT_PUSH, 8'($urandom_range(255)), 1'($urandom_range(1)),
                     16'($urandom_range(65535)));
        default: send_sequence($urandom_range(1, 40), $urandom_range(2),
                               ($urandom_range(1) != 0) ? 0 : 4);
      endcase
    end
  endtask

  // hold the sender until every result is back and the pipe has emptied
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_offset(input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_wdata_i   <= '0;
    s_idle_pct = 34;
    r_idle_pct = 55;
    sent       = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty buckets, pushes without a start, masking letters,
    // a homopolymer run with back-to-back equal keys, reads of filled buckets
    send_item(ACT_READ, 8'h00, 1'b0, 16'h0000);
    send_item(ACT_READ, 8'hFF, 1'b1, 16'hFFFF);
    for (int i = 0; i < 8; i++) send_item(ACT_PUSH, acgt_letter(i % 4), 1'b0, 16'h0000);
    send_item(ACT_PUSH, 8'h00, 1'b0, 16'hFFFF);
    send_item(ACT_PUSH, 8'hFF, 1'b0, 16'h0000);
    for (int i = 0; i < 10; i++) send_item(ACT_PUSH, LETTER_T, (i == 0), 16'h0000);
    send_item(ACT_READ, 8'h00, 1'b0, 16'hFFFF);
    send_item(ACT_READ, 8'h00, 1'b0, 16'h1B1B);
    wait_idle();

    // offset zero gives an entry zero
    write_offset(32'h0000_0000);
    random_items(140);
    wait_idle();
    write_offset(32'hFFFF_FFFF);
    random_items(140);
    wait_idle();

    s_idle_pct = 55;
    r_idle_pct = 34;
    // one long clean run wraps the entry index through zero
    write_offset(32'hFFFF_FF80);
    send_sequence(300, STYLE_ANY, 0);
    random_items(60);
    wait_idle();
    write_offset($urandom);
    random_items(140);
    wait_idle();

    s_idle_pct = 0;
    r_idle_pct = 0;
    write_offset(32'h0000_0001);
    random_items(140);
    wait_idle();
    write_offset($urandom);
    random_items(140);
    wait_idle();

    if (errors == 0) begin
      $display("** kmer_bucket_indexer: PASSED **");
    end else begin
      $display("** kmer_bucket_indexer: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/kbi_pkg.sv
rtl/core/kbi_ram.sv
rtl/core/kbi_roller.sv
rtl/core/kbi_update.sv
rtl/core/kmer_bucket_indexer.sv
tb/sv/kmer_bucket_indexer_checker.sv
tb/sv/kmer_bucket_indexer_tb.sv
